[src/gasp_pkg.sv]
`timescale 1ns / 1ps

package gasp_pkg;

    // Status codes of a search result word.
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_NO_PATH  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam int CELLS = 4096;
    localparam int CW    = 12;   // cell index width
    localparam int FW    = 13;   // estimate width
    localparam int KW    = 25;   // open set key width

    typedef logic [CW-1:0] t_cell;
    typedef logic [KW-1:0] t_key;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLEAR,
        S_PUSH_SRC,
        S_POP_CHECK,
        S_POP_RD0,
        S_POP_RDL,
        S_POP_WAITL,
        S_SIFT_RD,
        S_SIFT_WAIT,
        S_SIFT_CMP,
        S_SIFT_END,
        S_EXP_CELL,
        S_EXP_CELLW,
        S_NB_SEL,
        S_NB_WAIT,
        S_NB_EVAL,
        S_UP_RD,
        S_UP_WAIT,
        S_UP_CMP,
        S_WALK_RD,
        S_WALK_WAIT,
        S_WALK_STEP,
        S_DONE
    } t_state;

    // Per-cell search record: cost, estimate, parent and the flags.
    typedef struct packed {
        logic           closed;
        logic           est_set;
        logic           par_set;
        logic [CW-1:0]  cost;
        logic [FW-1:0]  est;
        logic [CW-1:0]  parent;
    } t_rec;

    // Absolute difference of two six bit coordinates.
    function automatic logic [6:0] absdiff(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] r;
        r = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
        return r;
    endfunction

endpackage

[src/gasp_heap.sv]
`timescale 1ns / 1ps

// Open set storage: one synchronous memory with a registered read port.
module gasp_heap #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  gasp_pkg::t_key      i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output gasp_pkg::t_key      o_rdata
);

    gasp_pkg::t_key r_mem [DEPTH];
    gasp_pkg::t_key r_rd;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

[src/gasp_cellmem.sv]
`timescale 1ns / 1ps

// Wall map and per-cell search records, one entry per grid cell.
module gasp_cellmem (
    input  logic                i_clk,
    input  logic                i_wall_we,
    input  gasp_pkg::t_cell     i_wall_waddr,
    input  logic                i_wall_wdata,
    input  gasp_pkg::t_cell     i_wall_raddr,
    output logic                o_wall_rdata,
    input  logic                i_rec_we,
    input  gasp_pkg::t_cell     i_rec_waddr,
    input  gasp_pkg::t_rec      i_rec_wdata,
    input  gasp_pkg::t_cell     i_rec_raddr,
    output gasp_pkg::t_rec      o_rec_rdata
);

    logic            r_wall [gasp_pkg::CELLS];
    gasp_pkg::t_rec  r_rec  [gasp_pkg::CELLS];
    logic            r_wall_rd;
    gasp_pkg::t_rec  r_rec_rd;

    // Wall map memory.
    always_ff @(posedge i_clk) begin
        if (i_wall_we) begin
            r_wall[i_wall_waddr] <= i_wall_wdata;
        end
        r_wall_rd <= r_wall[i_wall_raddr];
    end

    // Search record memory.
    always_ff @(posedge i_clk) begin
        if (i_rec_we) begin
            r_rec[i_rec_waddr] <= i_rec_wdata;
        end
        r_rec_rd <= r_rec[i_rec_raddr];
    end

    assign o_wall_rdata = r_wall_rd;
    assign o_rec_rdata  = r_rec_rd;

endmodule

[src/grid_astar_path_search_unit.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake           | Words
// ---------+-----------+---------------------+-------------------------------------
// input    | in        | i_valid / o_ready   | wall write or search request
// output   | out       | o_valid / i_ready   | status, next cell, path length
//
// After the synchronous reset the wall map is cleared before o_ready rises.
// A wall write holds o_ready low while it is written. A search clears the 4096 record entries,
// then pops, sifts and checks four neighbours with one memory access per step, then walks the
// parents back. Words are accepted while a result word waits; a search that ends meanwhile holds
// in its done state until the waiting word is taken, stalling the input.
module grid_astar_path_search_unit #(
    parameter int GRID_SIZE  = 64,
    parameter int OPEN_DEPTH = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [5:0]  i_cell_row,
    input  logic [5:0]  i_cell_col,
    input  logic        i_is_wall,
    input  logic [5:0]  i_src_row,
    input  logic [5:0]  i_src_col,
    input  logic [5:0]  i_dst_row,
    input  logic [5:0]  i_dst_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [5:0]  o_next_row,
    output logic [5:0]  o_next_col,
    output logic [11:0] o_path_length
);

    localparam int EXT   = (GRID_SIZE < 64) ? GRID_SIZE : 64;
    localparam int AW    = $clog2(OPEN_DEPTH);
    localparam int CNTW  = AW + 1;
    localparam logic [6:0] EXT7 = 7'(EXT);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(OPEN_DEPTH);

    gasp_pkg::t_state r_state, n_state;

    // Control registers.
    logic                 r_init;
    logic [12:0]          r_clr;
    logic [CNTW-1:0]      r_cnt;
    logic [AW:0]          r_i;
    logic [AW:0]          r_m;
    gasp_pkg::t_key       r_last;
    gasp_pkg::t_key       r_lkey;
    gasp_pkg::t_cell      r_cell;
    gasp_pkg::t_rec       r_crec;
    logic [2:0]           r_k;
    gasp_pkg::t_cell      r_nb;
    gasp_pkg::t_key       r_nkey;
    logic [5:0]           r_dr, r_dc;
    gasp_pkg::t_cell      r_src, r_dst;
    gasp_pkg::t_cell      r_cur, r_nxt;
    logic [12:0]          r_len;
    logic                 r_ovalid;
    logic [1:0]           r_ost;
    logic [1:0]           r_ostat;
    logic [5:0]           r_orow, r_ocol;
    logic [11:0]          r_olen;
    logic                 r_wall_pend;
    gasp_pkg::t_cell      r_wall_addr;
    logic                 r_wall_val;

    // Memory port signals.
    logic                 hp_we;
    logic [AW-1:0]        hp_waddr, hp_raddr;
    gasp_pkg::t_key       hp_wdata, hp_rdata;
    logic                 wl_we, wl_rd;
    gasp_pkg::t_cell      wl_waddr, wl_raddr;
    logic                 wl_wdata;
    logic                 rc_we;
    gasp_pkg::t_cell      rc_waddr, rc_raddr;
    gasp_pkg::t_rec       rc_wdata, rc_rdata;

    gasp_heap #(.DEPTH(OPEN_DEPTH), .AW(AW)) u_heap (
        .i_clk   (i_clk),
        .i_we    (hp_we),
        .i_waddr (hp_waddr),
        .i_wdata (hp_wdata),
        .i_raddr (hp_raddr),
        .o_rdata (hp_rdata)
    );

    gasp_cellmem u_cells (
        .i_clk        (i_clk),
        .i_wall_we    (wl_we),
        .i_wall_waddr (wl_waddr),
        .i_wall_wdata (wl_wdata),
        .i_wall_raddr (wl_raddr),
        .o_wall_rdata (wl_rd),
        .i_rec_we     (rc_we),
        .i_rec_waddr  (rc_waddr),
        .i_rec_wdata  (rc_wdata),
        .i_rec_raddr  (rc_raddr),
        .o_rec_rdata  (rc_rdata)
    );

    // Neighbour coordinates of the expanded cell.
    logic [5:0] cr, cc;
    logic [6:0] nr7, nc7;
    logic       nb_in;
    assign cr = r_cell[11:6];
    assign cc = r_cell[5:0];
    always_comb begin
        nr7 = {1'b0, cr};
        nc7 = {1'b0, cc};
        case (r_k[1:0])
            2'd0: nr7 = {1'b0, cr} - 7'd1;
            2'd1: nr7 = {1'b0, cr} + 7'd1;
            2'd2: nc7 = {1'b0, cc} + 7'd1;
            default: nc7 = {1'b0, cc} - 7'd1;
        endcase
        nb_in = (nr7 < EXT7) && (nc7 < EXT7);
    end

    // Neighbour cost and estimate.
    logic [11:0] ng;
    logic [12:0] nf;
    assign ng = r_crec.cost + 12'd1;
    assign nf = {1'b0, ng} + 13'(gasp_pkg::absdiff(r_nb[11:6], r_dr))
              + 13'(gasp_pkg::absdiff(r_nb[5:0], r_dc));

    // Heap left child for the sift-down and parent for the sift-up.
    logic [AW:0] lchild;
    assign lchild = {r_i[AW-1:0], 1'b1};
    logic [AW:0] parent_i;
    assign parent_i = (r_i - 1'b1) >> 1;

    // Smaller child and whether it moves up: left key in r_lkey, right key on the read port.
    logic            sift_two;
    gasp_pkg::t_key  sift_val;
    logic [AW:0]     sift_idx;
    logic            sift_go;
    assign sift_two = ((r_m + 1'b1) < r_cnt) && (hp_rdata < r_lkey);
    assign sift_val = sift_two ? hp_rdata : r_lkey;
    assign sift_idx = sift_two ? r_m + 1'b1 : r_m;
    assign sift_go  = sift_val < r_last;

    // The finished result moves into the output register once it is free.
    logic done_go;
    assign done_go = (r_state == gasp_pkg::S_DONE) && (!r_ovalid || i_ready);

    logic acc_in;
    assign acc_in  = i_valid && o_ready;
    assign o_ready = r_init && (r_state == gasp_pkg::S_IDLE) && !r_wall_pend;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gasp_pkg::S_IDLE: begin
                if (acc_in && i_action) begin
                    if (i_src_row >= 6'(EXT7) && EXT < 64 || i_src_col >= 6'(EXT7) && EXT < 64
                        || {i_src_row, i_src_col} == {i_dst_row, i_dst_col}) begin
                        n_state = gasp_pkg::S_DONE;
                    end else begin
                        n_state = gasp_pkg::S_CLEAR;
                    end
                end
            end
            gasp_pkg::S_CLEAR:     if (r_clr[12]) n_state = gasp_pkg::S_PUSH_SRC;
            gasp_pkg::S_PUSH_SRC:  n_state = gasp_pkg::S_POP_CHECK;
            gasp_pkg::S_POP_CHECK: n_state = (r_cnt == '0) ? gasp_pkg::S_DONE
                                                            : gasp_pkg::S_POP_RD0;
            gasp_pkg::S_POP_RD0:   n_state = gasp_pkg::S_POP_RDL;
            gasp_pkg::S_POP_RDL:   n_state = gasp_pkg::S_POP_WAITL;
            gasp_pkg::S_POP_WAITL: n_state = gasp_pkg::S_SIFT_RD;
            gasp_pkg::S_SIFT_RD: begin
                if (lchild >= (AW+1)'(r_cnt)) n_state = gasp_pkg::S_SIFT_END;
                else n_state = gasp_pkg::S_SIFT_WAIT;
            end
            gasp_pkg::S_SIFT_WAIT: n_state = gasp_pkg::S_SIFT_CMP;
            gasp_pkg::S_SIFT_CMP: begin
                if (sift_go) n_state = gasp_pkg::S_SIFT_RD;
                else n_state = gasp_pkg::S_SIFT_END;
            end
            gasp_pkg::S_SIFT_END:  n_state = gasp_pkg::S_EXP_CELL;
            gasp_pkg::S_EXP_CELL:  n_state = gasp_pkg::S_EXP_CELLW;
            gasp_pkg::S_EXP_CELLW: n_state = gasp_pkg::S_NB_SEL;
            gasp_pkg::S_NB_SEL: begin
                if (r_k[2]) n_state = gasp_pkg::S_POP_CHECK;
                else if (nb_in) n_state = gasp_pkg::S_NB_WAIT;
            end
            gasp_pkg::S_NB_WAIT:   n_state = gasp_pkg::S_NB_EVAL;
            gasp_pkg::S_NB_EVAL: begin
                if (wl_rd || rc_rdata.closed) n_state = gasp_pkg::S_NB_SEL;
                else if (r_nb == r_dst) n_state = gasp_pkg::S_WALK_RD;
                else if (!rc_rdata.est_set || nf < rc_rdata.est) begin
                    if (r_cnt >= DEPTH_C) n_state = gasp_pkg::S_DONE;
                    else n_state = gasp_pkg::S_UP_RD;
                end else n_state = gasp_pkg::S_NB_SEL;
            end
            gasp_pkg::S_UP_RD: begin
                if (r_i == '0) n_state = gasp_pkg::S_NB_SEL;
                else n_state = gasp_pkg::S_UP_WAIT;
            end
            gasp_pkg::S_UP_WAIT:   n_state = gasp_pkg::S_UP_CMP;
            gasp_pkg::S_UP_CMP: begin
                if (hp_rdata <= r_nkey) n_state = gasp_pkg::S_NB_SEL;
                else n_state = gasp_pkg::S_UP_RD;
            end
            gasp_pkg::S_WALK_RD:   n_state = gasp_pkg::S_WALK_WAIT;
            gasp_pkg::S_WALK_WAIT: n_state = gasp_pkg::S_WALK_STEP;
            gasp_pkg::S_WALK_STEP: begin
                if (!rc_rdata.par_set || rc_rdata.parent == r_cur || r_len[12])
                    n_state = gasp_pkg::S_DONE;
                else n_state = gasp_pkg::S_WALK_RD;
            end
            gasp_pkg::S_DONE:      if (done_go) n_state = gasp_pkg::S_IDLE;
            default:               n_state = gasp_pkg::S_IDLE;
        endcase
    end

    // Memory port drive.
    always_comb begin
        hp_we    = 1'b0;
        hp_waddr = r_i[AW-1:0];
        hp_wdata = r_last;
        hp_raddr = '0;
        rc_we    = 1'b0;
        rc_waddr = r_cell;
        rc_wdata = r_crec;
        rc_raddr = r_nb;
        wl_raddr = r_nb;
        wl_we    = r_wall_pend || !r_init;
        wl_waddr = r_init ? r_wall_addr : r_clr[11:0];
        wl_wdata = r_init ? r_wall_val : 1'b0;
        unique case (r_state)
            gasp_pkg::S_CLEAR: begin
                rc_we    = !r_clr[12];
                rc_waddr = r_clr[11:0];
                rc_wdata = '0;
            end
            gasp_pkg::S_PUSH_SRC: begin
                hp_we    = 1'b1;
                hp_waddr = '0;
                hp_wdata = gasp_pkg::t_key'(r_src);
                rc_we    = 1'b1;
                rc_waddr = r_src;
                rc_wdata = '{closed: 1'b0, est_set: 1'b1, par_set: 1'b1,
                             cost: '0, est: '0, parent: r_src};
            end
            gasp_pkg::S_POP_RD0:  hp_raddr = '0;
            gasp_pkg::S_POP_RDL:  hp_raddr = AW'(r_cnt - 1'b1);
            gasp_pkg::S_SIFT_RD:  hp_raddr = lchild[AW-1:0];
            gasp_pkg::S_SIFT_WAIT: hp_raddr = AW'(lchild + 1'b1);
            gasp_pkg::S_SIFT_CMP: begin
                if (sift_go) begin
                    hp_we    = 1'b1;
                    hp_waddr = r_i[AW-1:0];
                    hp_wdata = sift_val;
                end
            end
            gasp_pkg::S_SIFT_END: begin
                hp_we    = (r_cnt != '0);
                hp_waddr = r_i[AW-1:0];
                hp_wdata = r_last;
                rc_raddr = r_cell;
            end
            gasp_pkg::S_EXP_CELL:  rc_raddr = r_cell;
            gasp_pkg::S_EXP_CELLW: begin
                rc_we    = 1'b1;
                rc_waddr = r_cell;
                rc_wdata = rc_rdata;
                rc_wdata.closed = 1'b1;
            end
            gasp_pkg::S_NB_SEL: begin
                rc_raddr = {nr7[5:0], nc7[5:0]};
                wl_raddr = {nr7[5:0], nc7[5:0]};
            end
            gasp_pkg::S_NB_EVAL: begin
                if (!(wl_rd || rc_rdata.closed)) begin
                    rc_we    = 1'b1;
                    rc_waddr = r_nb;
                    rc_wdata = rc_rdata;
                    rc_wdata.parent  = r_cell;
                    rc_wdata.par_set = 1'b1;
                    if (r_nb != r_dst) begin
                        rc_we = (!rc_rdata.est_set || nf < rc_rdata.est) && (r_cnt < DEPTH_C);
                        rc_wdata.est     = nf;
                        rc_wdata.est_set = 1'b1;
                        rc_wdata.cost    = ng;
                    end
                end
            end
            gasp_pkg::S_UP_RD: begin
                hp_raddr = parent_i[AW-1:0];
                if (r_i == '0) begin
                    hp_we    = 1'b1;
                    hp_waddr = '0;
                    hp_wdata = r_nkey;
                end
            end
            gasp_pkg::S_UP_WAIT: hp_raddr = parent_i[AW-1:0];
            gasp_pkg::S_UP_CMP: begin
                hp_we    = 1'b1;
                hp_waddr = r_i[AW-1:0];
                hp_wdata = (hp_rdata <= r_nkey) ? r_nkey : hp_rdata;
            end
            gasp_pkg::S_WALK_RD:   rc_raddr = r_cur;
            gasp_pkg::S_WALK_WAIT: rc_raddr = r_cur;
            default: ;
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gasp_pkg::S_IDLE;
            r_init      <= 1'b0;
            r_clr       <= '0;
            r_ovalid    <= 1'b0;
            r_wall_pend <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (!r_init) begin
                if (r_clr[11:0] == 12'hFFF) begin
                    r_init <= 1'b1;
                    r_clr  <= '0;
                end else begin
                    r_clr  <= r_clr + 13'd1;
                end
            end
            if (done_go) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            r_wall_pend <= 1'b0;
            unique case (r_state)
                gasp_pkg::S_IDLE: begin
                    if (r_init) r_clr <= '0;
                    r_ost <= gasp_pkg::ST_NO_PATH;
                    if (acc_in) begin
                        if (!i_action) begin
                            r_wall_pend <= ({1'b0, i_cell_row} < EXT7)
                                        && ({1'b0, i_cell_col} < EXT7);
                            r_wall_addr <= {i_cell_row, i_cell_col};
                            r_wall_val  <= i_is_wall;
                        end
                        r_src <= {i_src_row, i_src_col};
                        r_dst <= {i_dst_row, i_dst_col};
                        r_dr  <= i_dst_row;
                        r_dc  <= i_dst_col;
                    end
                end
                gasp_pkg::S_CLEAR:    r_clr <= r_clr + 13'd1;
                gasp_pkg::S_PUSH_SRC: r_cnt <= CNTW'(1);
                gasp_pkg::S_POP_RDL:  r_cnt <= r_cnt - 1'b1;
                gasp_pkg::S_POP_WAITL: begin
                    r_cell <= r_lkey[11:0];
                    r_i    <= '0;
                end
                gasp_pkg::S_SIFT_CMP: if (sift_go) r_i <= sift_idx;
                gasp_pkg::S_SIFT_END: r_k <= '0;
                gasp_pkg::S_EXP_CELLW: r_crec <= rc_rdata;
                gasp_pkg::S_NB_SEL: begin
                    r_nb <= {nr7[5:0], nc7[5:0]};
                    if (!r_k[2] && !nb_in) r_k <= r_k + 3'd1;
                end
                gasp_pkg::S_NB_EVAL: begin
                    r_k  <= r_k + 3'd1;
                    r_i  <= (AW+1)'(r_cnt);
                    r_nkey <= {nf, r_nb};
                    if (!(wl_rd || rc_rdata.closed)) begin
                        if (r_nb == r_dst) begin
                            r_cur <= r_dst;
                            r_nxt <= r_dst;
                            r_len <= '0;
                        end else if (!rc_rdata.est_set || nf < rc_rdata.est) begin
                            if (r_cnt >= DEPTH_C) r_ost <= gasp_pkg::ST_OVERFLOW;
                            else r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                gasp_pkg::S_UP_CMP: if (hp_rdata > r_nkey) r_i <= parent_i;
                gasp_pkg::S_WALK_STEP: begin
                    if (!(!rc_rdata.par_set || rc_rdata.parent == r_cur || r_len[12])) begin
                        r_nxt <= r_cur;
                        r_cur <= rc_rdata.parent;
                        r_len <= r_len + 13'd1;
                    end else begin
                        r_ost <= gasp_pkg::ST_FOUND;
                    end
                end
                gasp_pkg::S_DONE: begin
                    if (done_go) begin
                        r_ostat  <= r_ost;
                        r_orow   <= (r_ost == gasp_pkg::ST_FOUND) ? r_nxt[11:6] : 6'd0;
                        r_ocol   <= (r_ost == gasp_pkg::ST_FOUND) ? r_nxt[5:0] : 6'd0;
                        r_olen   <= (r_ost != gasp_pkg::ST_FOUND) ? 12'd0 :
                                    (r_len > 13'd4095) ? 12'd4095 : r_len[11:0];
                    end
                end
                default: ;
            endcase
            // Sift-down bookkeeping on pop.
            if (r_state == gasp_pkg::S_POP_WAITL) r_last <= hp_rdata;
            if (r_state == gasp_pkg::S_POP_RDL) r_lkey <= hp_rdata;
            if (r_state == gasp_pkg::S_SIFT_RD) r_m <= lchild;
            if (r_state == gasp_pkg::S_SIFT_WAIT) r_lkey <= hp_rdata;
        end
    end

    // Result word outputs.
    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_next_row    = r_orow;
    assign o_next_col    = r_ocol;
    assign o_path_length = r_olen;

endmodule
